// ===== rtl/core/sha1_pkg.sv =====
// Shared types, constants and round functions of the SHA-1 hash engine.
package sha1_pkg;

	localparam int NUM_WORDS   = 5;
	localparam int NUM_ROUNDS  = 80;
	localparam int BLOCK_BYTES = 64;
	localparam int LEN_POS     = 56;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] IV [0:4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam logic [31:0] ROUND_K [0:3] = '{
		32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
	};

	typedef enum logic [1:0] {
		PH_CHOOSE = 2'd0,
		PH_PARITY = 2'd1,
		PH_MAJOR  = 2'd2,
		PH_PARITY2 = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       byte_present;
		logic       end_of_message;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_item_t;

	typedef struct packed {
		logic   start;
		logic   step;
		logic   finish;
		logic   iv_load;
		phase_t phase;
	} round_ctrl_t;

	typedef struct packed {
		logic       byte_en;
		logic [7:0] data;
		logic       step;
	} sched_ctrl_t;

	function automatic logic [31:0] round_f(phase_t ph, logic [31:0] b, logic [31:0] c,
		logic [31:0] d);
		logic [31:0] f;
		unique case (ph)
			PH_CHOOSE: f = (b & c) | (~b & d);
			PH_MAJOR:  f = (b & c) | (b & d) | (c & d);
			default:   f = b ^ c ^ d;
		endcase
		return f;
	endfunction

endpackage

// ===== rtl/core/sha1_sched.sv =====
// Message schedule: 16-word shift line, loaded a byte at a time, rolled once per round.
module sha1_sched (
	input  logic                  clk,
	input  sha1_pkg::sched_ctrl_t ctrl,
	output logic [31:0]           w
);

	// word 0 (oldest) sits at the top of the line
	logic [511:0] line_q;
	logic [31:0]  mix;
	logic [31:0]  next_word;

	assign w         = line_q[511:480];
	assign mix       = line_q[511:480] ^ line_q[447:416] ^ line_q[255:224] ^ line_q[95:64];
	assign next_word = {mix[30:0], mix[31]};

	always_ff @(posedge clk) begin
		if (ctrl.byte_en) begin
			line_q <= {line_q[503:0], ctrl.data};
		end else if (ctrl.step) begin
			line_q <= {line_q[479:0], next_word};
		end
	end

endmodule

// ===== rtl/core/sha1_round.sv =====
// Round unit: working registers a..e, one SHA-1 round per cycle while ctrl.step is high, and the chaining value.
module sha1_round (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha1_pkg::round_ctrl_t ctrl,
	input  logic [31:0]           w,
	output logic [4:0][31:0]      chain
);

	logic [4:0][31:0] chain_q;
	logic [31:0]      a_q, b_q, c_q, d_q, e_q;
	logic [31:0]      t;

	assign t = {a_q[26:0], a_q[31:27]} + sha1_pkg::round_f(ctrl.phase, b_q, c_q, d_q)
		+ e_q + sha1_pkg::ROUND_K[ctrl.phase] + w;

	assign chain = chain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
			c_q <= '0;
			d_q <= '0;
			e_q <= '0;
		end else if (ctrl.start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (ctrl.step) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) chain_q[i] <= sha1_pkg::IV[i];
		end else if (ctrl.iv_load) begin
			for (int i = 0; i < sha1_pkg::NUM_WORDS; i++) chain_q[i] <= sha1_pkg::IV[i];
		end else if (ctrl.finish) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
			chain_q[4] <= chain_q[4] + e_q;
		end
	end

endmodule

// ===== rtl/core/sha1_hash_engine.sv =====
// SHA-1 hash engine top level: byte intake, padding sequencer and digest output.
// A byte request that fills a 64-byte block holds the intake while the shared round unit
// runs its 80 rounds and then the chaining add.
// A closing request adds one padding byte per cycle up to the block end, one or two
// compressions, then the five digest words at one per cycle while digest_stall is low.
// Reset loads the standard initial value and clears counters; the schedule is not reset.
module sha1_hash_engine (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   msg_valid,
	output logic                   msg_stall,
	input  sha1_pkg::msg_item_t    msg,
	output logic                   digest_valid,
	input  logic                   digest_stall,
	output sha1_pkg::digest_item_t digest
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_FIN   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	localparam logic [6:0] ROUND_LAST = 7'(sha1_pkg::NUM_ROUNDS - 1);
	localparam logic [5:0] POS_LAST   = 6'(sha1_pkg::BLOCK_BYTES - 1);
	localparam logic [5:0] POS_LEN    = 6'(sha1_pkg::LEN_POS);
	localparam logic [2:0] IDX_LAST   = 3'(sha1_pkg::NUM_WORDS - 1);

	state_t       state_q;
	logic [6:0]   rnd_q;
	logic [5:0]   pos_q;
	logic [63:0]  count_q;
	logic         closing_q;
	logic         mark_q;
	logic         len_go_q;
	logic         len_done_q;
	logic [2:0]   idx_q;
	logic         digest_valid_q;
	sha1_pkg::digest_item_t digest_q;

	logic         msg_acc;
	logic         pad_len;
	logic [63:0]  len_shift;
	logic [7:0]   pad_data;
	logic         byte_en;
	logic         wrap;
	logic         out_load;
	logic [31:0]  w;
	logic [4:0][31:0] chain;
	sha1_pkg::phase_t      phase;
	sha1_pkg::round_ctrl_t rctrl;
	sha1_pkg::sched_ctrl_t sctrl;

	assign msg_stall = (state_q != ST_IDLE);
	assign msg_acc   = msg_valid && !msg_stall;

	// length bytes go out once the mark is in and the block reaches byte 56
	assign pad_len   = mark_q && (len_go_q || pos_q == POS_LEN);
	assign len_shift = count_q << {pos_q[2:0], 3'b000};
	assign pad_data  = !mark_q ? sha1_pkg::PAD_MARK : (pad_len ? len_shift[63:56] : 8'h00);

	assign byte_en  = (msg_acc && msg.byte_present) || (state_q == ST_PAD);
	assign wrap     = byte_en && (pos_q == POS_LAST);
	assign out_load = (state_q == ST_OUT) && (!digest_valid_q || !digest_stall);

	always_comb begin
		if (rnd_q < 7'd20)      phase = sha1_pkg::PH_CHOOSE;
		else if (rnd_q < 7'd40) phase = sha1_pkg::PH_PARITY;
		else if (rnd_q < 7'd60) phase = sha1_pkg::PH_MAJOR;
		else                    phase = sha1_pkg::PH_PARITY2;
	end

	assign sctrl.byte_en = byte_en;
	assign sctrl.data    = (state_q == ST_PAD) ? pad_data : msg.msg_byte;
	assign sctrl.step    = (state_q == ST_ROUND);

	assign rctrl.start   = wrap;
	assign rctrl.step    = (state_q == ST_ROUND);
	assign rctrl.finish  = (state_q == ST_FIN);
	assign rctrl.iv_load = out_load && (idx_q == IDX_LAST);
	assign rctrl.phase   = phase;

	sha1_sched u_sched (
		.clk  (clk),
		.ctrl (sctrl),
		.w    (w)
	);

	sha1_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (rctrl),
		.w      (w),
		.chain  (chain)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rnd_q          <= '0;
			pos_q          <= '0;
			count_q        <= '0;
			closing_q      <= 1'b0;
			mark_q         <= 1'b0;
			len_go_q       <= 1'b0;
			len_done_q     <= 1'b0;
			idx_q          <= '0;
			digest_valid_q <= 1'b0;
		end else begin
			if (byte_en) pos_q <= pos_q + 6'd1;
			if (out_load)                        digest_valid_q <= 1'b1;
			else if (digest_valid_q && !digest_stall) digest_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						if (msg.byte_present) count_q <= count_q + 64'd8;
						closing_q <= msg.end_of_message;
						if (wrap)                    state_q <= ST_ROUND;
						else if (msg.end_of_message) state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					mark_q <= 1'b1;
					if (pad_len) len_go_q <= 1'b1;
					if (pad_len && pos_q == POS_LAST) len_done_q <= 1'b1;
					if (wrap) state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (rnd_q == ROUND_LAST) begin
						rnd_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						rnd_q <= rnd_q + 7'd1;
					end
				end
				ST_FIN: begin
					if (closing_q && len_done_q) state_q <= ST_OUT;
					else if (closing_q)          state_q <= ST_PAD;
					else                         state_q <= ST_IDLE;
				end
				ST_OUT: begin
					if (out_load) begin
						if (idx_q == IDX_LAST) begin
							idx_q      <= '0;
							count_q    <= '0;
							closing_q  <= 1'b0;
							mark_q     <= 1'b0;
							len_go_q   <= 1'b0;
							len_done_q <= 1'b0;
							state_q    <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			digest_q.digest_word <= chain[idx_q];
			digest_q.word_index  <= idx_q;
			digest_q.last_word   <= (idx_q == IDX_LAST);
		end
	end

	assign digest_valid = digest_valid_q;
	assign digest       = digest_q;

	a_round_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == ROUND_LAST) |=> (state_q == ST_FIN))
		else $error("round counter did not hand over to chaining add");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (digest.last_word == (digest.word_index == IDX_LAST)))
		else $error("last_word flag out of step with word index");

	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !closing_q) |=> (state_q == ST_IDLE))
		else $error("open message did not return to intake after a block");

	a_out_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (pos_q == '0 && len_done_q))
		else $error("digest output started before the padded block closed");

endmodule
